### sv/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the summed packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int unsigned MAX_HEADER  = 8;
  localparam int unsigned MAX_PAYLOAD = 255;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned HDR_W     = 64;
  localparam int unsigned HLEN_W    = 4;
  localparam int unsigned PLEN_W    = 8;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN  = 2'd2;

  localparam logic [HLEN_W-1:0] HEADER_LEN_RESET = 4'd2;

  // frame layout after clamping
  typedef struct packed {
    logic [HDR_W-1:0]  header_bytes;
    logic [HLEN_W-1:0] hlen;
    logic [PLEN_W-1:0] plen;
  } spd_layout_t;

  typedef struct packed {
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] data_index;
    logic              frame_done;
    logic              frame_ok;
  } spd_result_t;

endpackage

### sv/spd_byte_if.sv
// ----------------------------------------------------------------------------
// spd_byte_if
// Received byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

### sv/spd_result_if.sv
// ----------------------------------------------------------------------------
// spd_result_if
// Per-byte result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spd_result_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic       frame_done;
  logic       frame_ok;

  modport source (output valid, output data_valid, output data_byte, output data_index,
                  output frame_done, output frame_ok, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input data_index,
                  input frame_done, input frame_ok, output ready);
endinterface

### sv/spd_cfg_if.sv
// ----------------------------------------------------------------------------
// spd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/spd_cfg_regs.sv
// ----------------------------------------------------------------------------
// spd_cfg_regs
// Configuration registers; presents the clamped frame layout.
// ----------------------------------------------------------------------------
module spd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [spd_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [spd_pkg::HDR_W-1:0]       wr_data,
  output spd_pkg::spd_layout_t            layout
);
  import spd_pkg::*;

  logic [HDR_W-1:0]  header_bytes;
  logic [HLEN_W-1:0] header_len;
  logic [PLEN_W-1:0] payload_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= '0;
      header_len   <= HEADER_LEN_RESET;
      payload_len  <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_HEADER_BYTES: header_bytes <= wr_data;
        REG_HEADER_LEN:   header_len   <= wr_data[HLEN_W-1:0];
        REG_PAYLOAD_LEN:  payload_len  <= wr_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    layout.header_bytes = header_bytes;
    layout.hlen = ({28'd0, header_len} > 32'(MAX_HEADER)) ? HLEN_W'(MAX_HEADER) : header_len;
    layout.plen = ({24'd0, payload_len} > 32'(MAX_PAYLOAD)) ? PLEN_W'(MAX_PAYLOAD)
                                                            : payload_len;
  end

endmodule

### sv/spd_frame.sv
// ----------------------------------------------------------------------------
// spd_frame
// Frame tracker: header and length match, payload indexing, XOR/SUM checks.
// ----------------------------------------------------------------------------
module spd_frame (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [spd_pkg::BYTE_W-1:0]  rx_byte,
  input  spd_pkg::spd_layout_t        layout,
  output spd_pkg::spd_result_t        result
);
  import spd_pkg::*;

  logic [POS_W-1:0]  position, position_next;
  logic [BYTE_W-1:0] xor_acc, xor_acc_next;
  logic [BYTE_W-1:0] sum_acc, sum_acc_next;
  logic              xor_match, xor_match_next;

  logic [POS_W-1:0]  hl_pos;
  logic [POS_W-1:0]  xor_pos;
  logic [BYTE_W-1:0] want;

  always_comb begin
    hl_pos  = {5'd0, layout.hlen};
    xor_pos = hl_pos + POS_W'(1) + {1'b0, layout.plen};
    want    = layout.header_bytes[{position[2:0], 3'b000} +: BYTE_W];

    position_next  = position + POS_W'(1);
    xor_acc_next   = xor_acc ^ rx_byte;
    sum_acc_next   = sum_acc + rx_byte;
    xor_match_next = xor_match;
    result         = '0;

    if (position < hl_pos) begin
      if (rx_byte != want) begin
        position_next  = '0;
        xor_acc_next   = '0;
        sum_acc_next   = '0;
        xor_match_next = 1'b0;
      end
    end else if (position == hl_pos) begin
      if (rx_byte != layout.plen) begin
        position_next  = '0;
        xor_acc_next   = '0;
        sum_acc_next   = '0;
        xor_match_next = 1'b0;
      end
    end else if (position < xor_pos) begin
      result.data_valid = 1'b1;
      result.data_byte  = rx_byte;
      result.data_index = BYTE_W'(position - hl_pos - POS_W'(1));
    end else if (position == xor_pos) begin
      xor_acc_next   = xor_acc;
      xor_match_next = (rx_byte == xor_acc);
    end else begin
      // sum byte, or anything past it after a layout change
      result.frame_done = 1'b1;
      result.frame_ok   = xor_match && (rx_byte == sum_acc);
      position_next     = '0;
      xor_acc_next      = '0;
      sum_acc_next      = '0;
      xor_match_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      xor_acc   <= '0;
      sum_acc   <= '0;
      xor_match <= 1'b0;
    end else if (step) begin
      position  <= position_next;
      xor_acc   <= xor_acc_next;
      sum_acc   <= sum_acc_next;
      xor_match <= xor_match_next;
    end
  end

`ifndef SYNTHESIS
  a_restart_after_frame: assert property (@(posedge clk) disable iff (rst)
    step && result.frame_done |=> position == '0 && xor_acc == '0 && sum_acc == '0)
    else $error("state not cleared after frame end");

  a_done_or_data: assert property (@(posedge clk) disable iff (rst)
    !(result.data_valid && result.frame_done))
    else $error("payload byte and frame end on the same byte");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    result.frame_ok |-> result.frame_done)
    else $error("frame_ok without frame_done");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(MAX_HEADER + MAX_PAYLOAD + 2))
    else $error("position past the sum byte slot");
`endif

endmodule

### sv/summed_packet_deframer.sv
// ----------------------------------------------------------------------------
// summed_packet_deframer
// Recovers fixed-length frames (header, length, payload, XOR, SUM) from a
// received byte stream and reports payload bytes and frame check status.
//
// Channels: rx carries one received byte per transfer; res returns exactly one
// result per received byte (payload byte with its index, or frame end with the
// check outcome, or all zero). cfg writes header_bytes (0), header_len (1) and
// payload_len (2); it is always ready. The user must see that it is only
// written while idle; the block itself does not enforce it. A byte waits in
// the input register until the output register is free or being taken; the
// frame tracker then steps on it and loads its result there. Throughput: one
// byte per cycle while res.ready stays high; both registers are single entry.
// Reset (rst, synchronous): empties both registers, clears the frame state and
// loads header_len 2, header_bytes 0, payload_len 0.
// Receiver stall: the result holds in the output register; one more byte can
// wait in the input register, after which rx.ready drops.
// ----------------------------------------------------------------------------
module summed_packet_deframer (
  input  logic   clk,
  input  logic   rst,
  spd_cfg_if.sink      cfg,
  spd_byte_if.sink     rx,
  spd_result_if.source res
);
  import spd_pkg::*;

  spd_layout_t       layout;
  spd_result_t       step_result;
  spd_result_t       res_reg;
  logic              res_valid;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              advance;
  logic              rx_xfer;

  assign cfg.ready = 1'b1;
  assign advance   = s1_valid && (!res_valid || res.ready);
  assign rx.ready  = !s1_valid || advance;
  assign rx_xfer   = rx.valid && rx.ready;

  spd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .layout   (layout)
  );

  spd_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (s1_byte),
    .layout  (layout),
    .result  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1_valid  <= rx_xfer || (s1_valid && !advance);
      res_valid <= advance || (res_valid && !res.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (rx_xfer) begin
      s1_byte <= rx.in_byte;
    end
    if (advance) begin
      res_reg <= step_result;
    end
  end

  assign res.valid      = res_valid;
  assign res.data_valid = res_reg.data_valid;
  assign res.data_byte  = res_reg.data_byte;
  assign res.data_index = res_reg.data_index;
  assign res.frame_done = res_reg.frame_done;
  assign res.frame_ok   = res_reg.frame_ok;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.ready |=> res_valid && $stable(res_reg))
    else $error("stalled result overwritten");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte))
    else $error("waiting byte lost");

  a_idle_data_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_reg.data_valid |-> res_reg.data_byte == '0 && res_reg.data_index == '0)
    else $error("payload fields set without data_valid");
`endif

endmodule

### sim/summed_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// summed_packet_deframer_tb
// Self-checking bench for the deframer. Sends good frames, damaged frames and
// noise under changing layouts and idle patterns, predicts the result of every
// byte and checks each returned result in order.
// ----------------------------------------------------------------------------
module summed_packet_deframer_tb;
  import spd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum int {
    FAULT_NONE,
    FAULT_HEADER,
    FAULT_LENGTH,
    FAULT_XOR,
    FAULT_SUM,
    FAULT_TRUNCATE
  } frame_fault_e;

  logic clk = 1'b0;
  logic rst;

  spd_cfg_if    cfg_ch ();
  spd_byte_if   rx_ch ();
  spd_result_if res_ch ();

  summed_packet_deframer dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rx  (rx_ch),
    .res (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror and frame tracker of the predictor
  logic [HDR_W-1:0]  cfg_header_bytes;
  logic [HLEN_W-1:0] cfg_header_len;
  logic [PLEN_W-1:0] cfg_payload_len;
  logic [POS_W-1:0]  frame_pos;
  logic [7:0]        run_xor;
  logic [7:0]        run_sum;
  logic              xor_ok;

  spd_result_t expected_results[$];
  spd_result_t oldest_result;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned bytes_sent  = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  function automatic int unsigned layout_hlen();
    return (cfg_header_len > MAX_HEADER) ? MAX_HEADER : cfg_header_len;
  endfunction

  function automatic int unsigned layout_plen();
    return (cfg_payload_len > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_payload_len;
  endfunction

  function automatic void restart_frame();
    frame_pos = '0;
    run_xor   = '0;
    run_sum   = '0;
    xor_ok    = 1'b0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    run_xor   ^= b;
    run_sum   += b;
    frame_pos += 1'b1;
  endfunction

  // result of one received byte; advances the frame tracker
  function automatic spd_result_t deframe_byte(input logic [7:0] b);
    spd_result_t r;
    int unsigned hl, pl, xor_slot;
    r        = '0;
    hl       = layout_hlen();
    pl       = layout_plen();
    xor_slot = hl + 1 + pl;
    if (frame_pos < hl) begin
      if (b == cfg_header_bytes[frame_pos[2:0]*8 +: 8]) absorb_byte(b);
      else restart_frame();
    end else if (frame_pos == hl) begin
      if (32'(b) == pl) absorb_byte(b);
      else restart_frame();
    end else if (frame_pos < xor_slot) begin
      r.data_valid = 1'b1;
      r.data_byte  = b;
      r.data_index = 8'(frame_pos - hl - 1);
      absorb_byte(b);
    end else if (frame_pos == xor_slot) begin
      xor_ok    = (b == run_xor);
      run_sum  += b;
      frame_pos += 1'b1;
    end else begin
      // anything at or past the sum slot closes the frame
      r.frame_done = 1'b1;
      r.frame_ok   = xor_ok && (b == run_sum);
      restart_frame();
    end
    return r;
  endfunction

  // valid stays high after a transfer so a back-to-back byte needs no toggle
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.in_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    expected_results.push_back(deframe_byte(b));
    bytes_sent++;
  endtask

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_HEADER_BYTES: cfg_header_bytes = data;
      REG_HEADER_LEN:   cfg_header_len   = data[HLEN_W-1:0];
      REG_PAYLOAD_LEN:  cfg_payload_len  = data[PLEN_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // length registers get junk in the unused upper bits half the time
  task automatic set_layout(input logic [63:0] hb, input logic [3:0] hl, input logic [7:0] pl);
    logic [63:0] hl_word, pl_word;
    hl_word = 64'(hl);
    pl_word = 64'(pl);
    if ($urandom_range(0, 1) == 1) begin
      hl_word       = {$urandom, $urandom};
      hl_word[3:0]  = hl;
      pl_word       = {$urandom, $urandom};
      pl_word[7:0]  = pl;
    end
    drain_results();
    write_reg(REG_HEADER_BYTES, hb);
    write_reg(REG_HEADER_LEN, hl_word);
    write_reg(REG_PAYLOAD_LEN, pl_word);
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) send_byte(8'($urandom));
  endtask

  // builds one frame for the current layout, optionally damaged
  task automatic send_frame(input frame_fault_e fault);
    logic [7:0]  frame[$];
    logic [7:0]  chk_xor, chk_sum, pick;
    int unsigned hl, pl, spot;
    hl = layout_hlen();
    pl = layout_plen();
    for (int k = 0; k < hl; k++) frame.push_back(cfg_header_bytes[k*8 +: 8]);
    frame.push_back(8'(pl));
    repeat (pl) begin
      case ($urandom_range(0, 7))
        0:       pick = 8'h00;
        1:       pick = 8'hFF;
        default: pick = 8'($urandom);
      endcase
      frame.push_back(pick);
    end
    chk_xor = '0;
    chk_sum = '0;
    foreach (frame[i]) begin
      chk_xor ^= frame[i];
      chk_sum += frame[i];
    end
    chk_sum += chk_xor;
    frame.push_back(chk_xor);
    frame.push_back(chk_sum);
    case (fault)
      FAULT_HEADER: spot = (hl > 0) ? $urandom_range(0, hl - 1) : hl;
      FAULT_LENGTH: spot = hl;
      FAULT_XOR:    spot = hl + 1 + pl;
      FAULT_SUM:    spot = hl + 2 + pl;
      default:      spot = frame.size();
    endcase
    if (spot < frame.size()) frame[spot] ^= 8'($urandom_range(1, 255));
    if (fault == FAULT_TRUNCATE) repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task automatic test_reset_layout();
    send_frame(FAULT_NONE);
  endtask

  task automatic test_header_clamp();
    set_layout({$urandom, $urandom}, 4'd15, 8'd0);
    send_frame(FAULT_NONE);
    set_layout({$urandom, $urandom}, 4'd1, 8'd0);
    send_frame(FAULT_HEADER);
  endtask

  // empty header and empty payload: length byte first, xor right after it
  task automatic test_check_bytes();
    set_layout('1, 4'd0, 8'd0);
    send_frame(FAULT_LENGTH);
    send_frame(FAULT_XOR);
    send_frame(FAULT_SUM);
  endtask

  task automatic test_layout_change_mid_frame();
    set_layout({$urandom, $urandom}, 4'd1, 8'd3);
    send_byte(cfg_header_bytes[7:0]);
    send_byte(8'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain_results();
    // shorter payload puts the tracker past the sum slot
    write_reg(REG_PAYLOAD_LEN, 64'd0);
    send_byte(8'($urandom));
    set_layout({$urandom, $urandom}, 4'd2, 8'd0);
    send_byte(cfg_header_bytes[7:0]);
    drain_results();
    // dropping the header lands the tracker on the xor slot
    write_reg(REG_HEADER_LEN, 64'd0);
    send_byte(8'h00);
    send_byte(8'h00);
  endtask

  task automatic test_longest_frame();
    set_layout({$urandom, $urandom}, 4'd8, 8'd255);
    send_frame(FAULT_NONE);
  endtask

  task automatic test_random_traffic(input int unsigned budget);
    int unsigned start_count, frames_left;
    logic [63:0] hb;
    logic [3:0]  hl;
    logic [7:0]  pl;
    start_count = bytes_sent;
    while (bytes_sent - start_count < budget) begin
      case ($urandom_range(0, 3))
        0:       hb = '0;
        1:       hb = '1;
        default: hb = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
        0:       hl = 4'd0;
        1:       hl = 4'd8;
        2:       hl = 4'($urandom_range(9, 15));
        default: hl = 4'($urandom_range(1, 7));
      endcase
      pl = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(2, 12));
      set_layout(hb, hl, pl);
      frames_left = $urandom_range(3, 10);
      while (frames_left > 0 && bytes_sent - start_count < budget) begin
        if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 6));
        if ($urandom_range(0, 99) < 75) send_frame(FAULT_NONE);
        else send_frame(frame_fault_e'($urandom_range(FAULT_HEADER, FAULT_TRUNCATE)));
        frames_left--;
      end
    end
  endtask

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, actual %0h/%0h/%0h/%0h/%0h",
                 $time, res_ch.data_valid, res_ch.data_byte, res_ch.data_index,
                 res_ch.frame_done, res_ch.frame_ok);
        error_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        compare_field("data_valid", 8'(oldest_result.data_valid), 8'(res_ch.data_valid));
        compare_field("data_byte", oldest_result.data_byte, res_ch.data_byte);
        compare_field("data_index", oldest_result.data_index, res_ch.data_index);
        compare_field("frame_done", 8'(oldest_result.frame_done), 8'(res_ch.frame_done));
        compare_field("frame_ok", 8'(oldest_result.frame_ok), 8'(res_ch.frame_ok));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.in_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_HEADER_BYTES;
    cfg_ch.data   = '0;
    res_ch.ready  = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 76;
    cfg_header_bytes = '0;
    cfg_header_len   = HEADER_LEN_RESET;
    cfg_payload_len  = '0;
    restart_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_layout();
    test_header_clamp();
    test_check_bytes();
    test_layout_change_mid_frame();
    test_random_traffic(150);
    drain_results();

    send_idle_pct = 76;
    recv_idle_pct = 17;
    test_random_traffic(150);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_longest_frame();
    test_random_traffic(150);
    drain_results();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
